@@ rtl/assert_macros.svh @@
// Assertion macros used by the keyframe track interpolator RTL.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every enabled clock edge.
`define KTI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition must never be true at an enabled clock edge.
`define KTI_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ rtl/kti_pkg.sv @@
// Shared types and constants of the keyframe track interpolator.
// Used by kti_front, kti_queue, kti_back and the top level.
`default_nettype none
package kti_pkg;

   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 40;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = 3;
   localparam int QPTR_W      = 2;

   typedef enum logic [1:0] {
      KTI_MODE_WRITE = 2'd0,
      KTI_MODE_COUNT = 2'd1,
      KTI_MODE_EVAL  = 2'd2
   } kti_mode_type;

   // Operation after classification; VOID is an evaluation of a track that does not exist.
   typedef enum logic [1:0] {
      KTI_OP_WRITE = 2'd0,
      KTI_OP_COUNT = 2'd1,
      KTI_OP_EVAL  = 2'd2,
      KTI_OP_VOID  = 2'd3
   } kti_op_type;

   typedef enum logic [3:0] {
      KTI_ST_CLEAR,
      KTI_ST_IDLE,
      KTI_ST_SETUP,
      KTI_ST_SCAN,
      KTI_ST_CALC,
      KTI_ST_DIV,
      KTI_ST_MUL,
      KTI_ST_ADD,
      KTI_ST_DONE
   } kti_state_type;

   typedef struct packed {
      kti_op_type   op;
      logic [6:0]   track;
      logic [6:0]   key_index;
      logic [15:0]  key_row;
      logic         key_linear;
      logic [31:0]  key_value;
      logic [7:0]   key_count;
      logic [23:0]  query_row;
   } kti_cmd_type;

endpackage
`default_nettype wire

@@ rtl/kti_front.sv @@
// Front end: accepts request items, unpacks and range-checks them, and pushes commands.
// Depends on kti_pkg.
`default_nettype none
module kti_front #(
   parameter int TRACKS   = 128,
   parameter int MAX_KEYS = 128
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [kti_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [1:0]                       req_tuser,
   input  wire logic                             queue_full,
   input  wire logic                             clearing,
   output logic                                  push,
   output kti_pkg::kti_cmd_type                  cmd
);
   import kti_pkg::*;

   logic accept;
   logic track_ok;
   logic index_ok;

   assign req_tready = !queue_full && !clearing;
   assign accept     = req_tvalid && req_tready;
   assign track_ok   = 32'(req_tdata[6:0]) < TRACKS;
   assign index_ok   = 32'(req_tdata[13:7]) < MAX_KEYS;

   always_comb begin
      cmd.track      = req_tdata[6:0];
      cmd.key_index  = req_tdata[13:7];
      cmd.key_row    = req_tdata[29:14];
      cmd.key_linear = req_tdata[30];
      cmd.key_value  = req_tdata[62:31];
      cmd.query_row  = req_tdata[94:71];
      cmd.key_count  = (32'(req_tdata[70:63]) > MAX_KEYS) ? 8'(MAX_KEYS) : req_tdata[70:63];
      cmd.op         = KTI_OP_VOID;
      push           = 1'b0;
      unique case (kti_mode_type'(req_tuser))
         KTI_MODE_WRITE: begin
            cmd.op = KTI_OP_WRITE;
            push   = accept && track_ok && index_ok;
         end
         KTI_MODE_COUNT: begin
            cmd.op = KTI_OP_COUNT;
            push   = accept && track_ok;
         end
         KTI_MODE_EVAL: begin
            cmd.op = track_ok ? KTI_OP_EVAL : KTI_OP_VOID;
            push   = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // The front is purely combinational; clock and reset are kept for a uniform port set.
   logic unused_ok;
   assign unused_ok = clock ^ reset ^ req_tdata[95];

endmodule
`default_nettype wire

@@ rtl/kti_queue.sv @@
// Short command queue between the front end and the execution back end.
// Depends on kti_pkg.
`default_nettype none
module kti_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  kti_pkg::kti_cmd_type       cmd_in,
   output logic                       full,
   input  wire logic                  pop,
   output kti_pkg::kti_cmd_type       cmd_out,
   output logic                       empty
);
   import kti_pkg::*;

   kti_cmd_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;

   assign full    = fill_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty   = fill_ff == '0;
   assign cmd_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/kti_back.sv @@
// Back end: key, count and held-value stores, the segment scan, divider, multiplier
// and the result register. Depends on kti_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module kti_back #(
   parameter int TRACKS   = 128,
   parameter int MAX_KEYS = 128
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  kti_pkg::kti_cmd_type                  cmd,
   input  wire logic                             empty,
   output logic                                  pop,
   output logic                                  clearing,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [kti_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser
);
   import kti_pkg::*;

   localparam int TIW   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int KIW   = $clog2(MAX_KEYS);
   localparam int AW    = TIW + KIW;
   localparam int KDEPTH = 2 ** AW;

   kti_state_type state_ff, state_in;

   // Stores.
   logic [15:0] row_mem   [KDEPTH];
   logic        lin_mem   [KDEPTH];
   logic [31:0] val_mem   [KDEPTH];
   logic [7:0]  count_mem [TRACKS];
   logic [31:0] held_mem  [TRACKS];

   // Control registers.
   logic [TIW-1:0] clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           dvalid_ff, dvalid_in;
   logic [7:0]     iss_ff, iss_in;
   logic [3:0]     step_ff, step_in;
   logic           hit_ff, hit_in;

   // Payload registers.
   logic [TIW-1:0] trk_ff, trk_in;
   logic [6:0]     otrk_ff, otrk_in;
   logic [23:0]    q_ff, q_in;
   logic           bad_ff, bad_in;
   logic [7:0]     cnt_ff;
   logic [31:0]    held_ff;
   logic [15:0]    row_rd_ff;
   logic           lin_rd_ff;
   logic [31:0]    val_rd_ff;
   logic           dfirst_ff, dfirst_in;
   logic           dlast_ff, dlast_in;
   logic [15:0]    prow_ff, prow_in;
   logic           plin_ff, plin_in;
   logic [31:0]    pval_ff, pval_in;
   logic [15:0]    sr0_ff, sr0_in;
   logic [15:0]    sr1_ff, sr1_in;
   logic           slin_ff, slin_in;
   logic [31:0]    sv0_ff, sv0_in;
   logic [31:0]    sv1_ff, sv1_in;
   logic [23:0]    rem_ff, rem_in;
   logic [23:0]    den_ff, den_in;
   logic [15:0]    quo_ff, quo_in;
   logic signed [49:0] prod_ff, prod_in;
   logic [31:0]    res_ff, res_in;
   logic [6:0]     rtrk_ff, rtrk_in;
   logic [31:0]    rval_ff, rval_in;
   logic           rhit_ff, rhit_in;

   // Memory port controls.
   logic           key_we, key_re;
   logic [AW-1:0]  key_wa, key_ra;
   logic           cnt_we, held_we, trk_re;
   logic [TIW-1:0] cnt_wa, held_wa;
   logic [7:0]     cnt_wd;
   logic [31:0]    held_wd;

   logic           load_rsp;
   logic           seg_hit;
   logic           scan_end;
   logic [24:0]    rem2;
   logic           rem_ge;
   logic signed [32:0] vdiff;

   assign clearing   = state_ff == KTI_ST_CLEAR;
   assign pop        = (state_ff == KTI_ST_IDLE) && !empty;
   assign load_rsp   = (state_ff == KTI_ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign scan_end   = dvalid_ff && dlast_ff;
   assign seg_hit    = dvalid_ff && !dfirst_ff && ({prow_ff, 8'h00} <= q_ff)
                       && (q_ff < {row_rd_ff, 8'h00});
   assign rem2       = {rem_ff, 1'b0};
   assign rem_ge     = rem2 >= {1'b0, den_ff};
   assign vdiff      = $signed({sv1_ff[31], sv1_ff}) - $signed({sv0_ff[31], sv0_ff});

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rval_ff, rtrk_ff};
   assign rsp_tuser  = rhit_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         KTI_ST_CLEAR: begin
            if (clr_ff == TIW'(TRACKS - 1)) state_in = KTI_ST_IDLE;
         end
         KTI_ST_IDLE: begin
            if (pop && (cmd.op == KTI_OP_EVAL || cmd.op == KTI_OP_VOID)) begin
               state_in = KTI_ST_SETUP;
            end
         end
         KTI_ST_SETUP: begin
            state_in = (bad_ff || cnt_ff < 8'd2) ? KTI_ST_DONE : KTI_ST_SCAN;
         end
         KTI_ST_SCAN: begin
            if (scan_end) state_in = KTI_ST_CALC;
         end
         KTI_ST_CALC: begin
            if (hit_ff && slin_ff && (sr1_ff > sr0_ff)) state_in = KTI_ST_DIV;
            else state_in = KTI_ST_DONE;
         end
         KTI_ST_DIV: begin
            if (step_ff == 4'd15) state_in = KTI_ST_MUL;
         end
         KTI_ST_MUL: begin
            state_in = KTI_ST_ADD;
         end
         KTI_ST_ADD: begin
            state_in = KTI_ST_DONE;
         end
         KTI_ST_DONE: begin
            if (load_rsp) state_in = KTI_ST_IDLE;
         end
         default: begin
            state_in = KTI_ST_CLEAR;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      clr_in       = clr_ff + 1'b1;
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      dvalid_in    = 1'b0;
      iss_in       = iss_ff;
      step_in      = step_ff;
      hit_in       = hit_ff;
      trk_in       = trk_ff;
      otrk_in      = otrk_ff;
      q_in         = q_ff;
      bad_in       = bad_ff;
      dfirst_in    = dfirst_ff;
      dlast_in     = dlast_ff;
      prow_in      = prow_ff;
      plin_in      = plin_ff;
      pval_in      = pval_ff;
      sr0_in       = sr0_ff;
      sr1_in       = sr1_ff;
      slin_in      = slin_ff;
      sv0_in       = sv0_ff;
      sv1_in       = sv1_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rtrk_in      = rtrk_ff;
      rval_in      = rval_ff;
      rhit_in      = rhit_ff;
      key_we       = 1'b0;
      key_wa       = {TIW'(cmd.track), KIW'(cmd.key_index)};
      key_re       = 1'b0;
      key_ra       = {trk_ff, KIW'(iss_ff)};
      trk_re       = 1'b0;
      cnt_we       = 1'b0;
      cnt_wa       = TIW'(cmd.track);
      cnt_wd       = cmd.key_count;
      held_we      = 1'b0;
      held_wa      = trk_ff;
      held_wd      = res_ff;

      case (state_ff)
         KTI_ST_CLEAR: begin
            cnt_we  = 1'b1;
            cnt_wa  = clr_ff;
            cnt_wd  = '0;
            held_we = 1'b1;
            held_wa = clr_ff;
            held_wd = '0;
         end
         KTI_ST_IDLE: begin
            if (pop) begin
               key_we  = cmd.op == KTI_OP_WRITE;
               cnt_we  = cmd.op == KTI_OP_COUNT;
               trk_re  = 1'b1;
               trk_in  = TIW'(cmd.track);
               otrk_in = cmd.track;
               q_in    = cmd.query_row;
               bad_in  = cmd.op == KTI_OP_VOID;
            end
         end
         KTI_ST_SETUP: begin
            iss_in = '0;
            hit_in = 1'b0;
            res_in = bad_ff ? 32'd0 : held_ff;
         end
         KTI_ST_SCAN: begin
            // Reads are issued one key per cycle; the read data is registered and returns in the next cycle.
            if (iss_ff < cnt_ff) begin
               key_re    = 1'b1;
               iss_in    = iss_ff + 1'b1;
               dvalid_in = 1'b1;
               dfirst_in = iss_ff == 8'd0;
               dlast_in  = iss_ff == cnt_ff - 8'd1;
            end
            if (dvalid_ff) begin
               prow_in = row_rd_ff;
               plin_in = lin_rd_ff;
               pval_in = val_rd_ff;
            end
            // A later matching segment overrides an earlier one.
            if (seg_hit) begin
               hit_in  = 1'b1;
               sr0_in  = prow_ff;
               slin_in = plin_ff;
               sv0_in  = pval_ff;
               sr1_in  = row_rd_ff;
               sv1_in  = val_rd_ff;
            end
         end
         KTI_ST_CALC: begin
            if (hit_ff) begin
               res_in = sv0_ff;
            end
            rem_in  = q_ff - {sr0_ff, 8'h00};
            den_in  = {sr1_ff - sr0_ff, 8'h00};
            quo_in  = '0;
            step_in = '0;
         end
         KTI_ST_DIV: begin
            rem_in  = rem_ge ? 24'(rem2 - {1'b0, den_ff}) : rem2[23:0];
            quo_in  = {quo_ff[14:0], rem_ge};
            step_in = step_ff + 1'b1;
         end
         KTI_ST_MUL: begin
            prod_in = 50'(vdiff * $signed({1'b0, quo_ff}));
         end
         KTI_ST_ADD: begin
            res_in = prod_ff[47:16] + sv0_ff;
         end
         KTI_ST_DONE: begin
            if (load_rsp) begin
               rtrk_in = otrk_ff;
               rval_in = res_ff;
               rhit_in = hit_ff && !bad_ff;
               held_we = hit_ff && !bad_ff;
            end
         end
         default: begin
            dvalid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= KTI_ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dvalid_ff    <= 1'b0;
         iss_ff       <= '0;
         step_ff      <= '0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         dvalid_ff    <= dvalid_in;
         iss_ff       <= iss_in;
         step_ff      <= step_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      trk_ff    <= trk_in;
      otrk_ff   <= otrk_in;
      q_ff      <= q_in;
      bad_ff    <= bad_in;
      dfirst_ff <= dfirst_in;
      dlast_ff  <= dlast_in;
      prow_ff   <= prow_in;
      plin_ff   <= plin_in;
      pval_ff   <= pval_in;
      sr0_ff    <= sr0_in;
      sr1_ff    <= sr1_in;
      slin_ff   <= slin_in;
      sv0_ff    <= sv0_in;
      sv1_ff    <= sv1_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      rtrk_ff   <= rtrk_in;
      rval_ff   <= rval_in;
      rhit_ff   <= rhit_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         row_mem[key_wa] <= cmd.key_row;
         lin_mem[key_wa] <= cmd.key_linear;
         val_mem[key_wa] <= cmd.key_value;
      end
      if (key_re) begin
         row_rd_ff <= row_mem[key_ra];
         lin_rd_ff <= lin_mem[key_ra];
         val_rd_ff <= val_mem[key_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_wa] <= cnt_wd;
      end
      if (trk_re) begin
         cnt_ff <= count_mem[TIW'(cmd.track)];
      end
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem[held_wa] <= held_wd;
      end
      if (trk_re) begin
         held_ff <= held_mem[TIW'(cmd.track)];
      end
   end

   `KTI_ASSERT(a_div_needs_linear_hit, (state_ff == KTI_ST_DIV) |-> (hit_ff && slin_ff), "divider ran without a linear segment")
   `KTI_ASSERT_NEVER(a_no_pop_in_clear, (state_ff == KTI_ST_CLEAR) && pop, "command popped during clearing pass")
   `KTI_ASSERT(a_scan_issue_bound, dvalid_ff |-> (iss_ff <= cnt_ff), "key read issued beyond key count")

endmodule
`default_nettype wire

@@ rtl/keyframe_track_interpolator_unit.sv @@
// Keyframe track interpolator: accepts key writes, key counts and evaluations on req_,
// returns one rsp_ item per evaluation. Usage summary:
//   req_ channel: tuser = mode (write key, set key count, evaluate); tdata carries the
//   key and query fields. Writes and counts produce no response item.
//   rsp_ channel: tdata = out_track and out_value, tuser = matched.
//   A write or count item is carried out in the back end's idle state. An evaluation
//   scans the track's keys, then runs divide, multiply and add when it lands in a linear
//   segment; the key store's single read port, reading one key per cycle, sets the scan
//   length.
//   Items are handled one at a time by the back end; a four-entry queue lets the request
//   side keep accepting while an evaluation runs.
//   After reset the count and held-value stores are cleared track by track; during the
//   clearing pass req_tready stays low.
//   If rsp_tready is low the result waits in the output register, and a further evaluation
//   holds the back end in its final state; the queue keeps taking items until it fills.
// Depends on kti_pkg, kti_front, kti_queue and kti_back.
`default_nettype none
module keyframe_track_interpolator_unit #(
   parameter int TRACKS   = 128,
   parameter int MAX_KEYS = 128
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // track[6:0], key_index[13:7], key_row[29:14], key_linear[30], key_value[62:31],
   // key_count[70:63], query_row[94:71], zero[95]
   input  wire logic [kti_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode[1:0]
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // out_track[6:0], out_value[38:7], zero[39]
   output logic [kti_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // matched[0]
   output logic                                  rsp_tuser
);
   import kti_pkg::*;

   kti_cmd_type front_cmd;
   kti_cmd_type back_cmd;
   logic        push;
   logic        pop;
   logic        full;
   logic        empty;
   logic        clearing;

   kti_front #(
      .TRACKS   (TRACKS),
      .MAX_KEYS (MAX_KEYS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (full),
      .clearing   (clearing),
      .push       (push),
      .cmd        (front_cmd)
   );

   kti_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .cmd_in  (front_cmd),
      .full    (full),
      .pop     (pop),
      .cmd_out (back_cmd),
      .empty   (empty)
   );

   kti_back #(
      .TRACKS   (TRACKS),
      .MAX_KEYS (MAX_KEYS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (back_cmd),
      .empty      (empty),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
